// ===== hdl/prspw_pkg.sv =====
// Shared types, field layout and constants for the palette rotate/scale pixel writer.
`timescale 1ns / 1ps

package prspw_pkg;

  // Field widths
  localparam int COLOR_W  = 8;
  localparam int IDX_W    = 8;
  localparam int COL_W    = 9;
  localparam int ROW_W    = 8;
  localparam int SCR_W    = 12;
  localparam int STRIDE_W = 16;
  localparam int SCALE_W  = 16;
  localparam int FRAC_W   = 8;
  localparam int ADDR_W   = 30;
  localparam int RGB565_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Coordinate compare width, wide enough for any source dimension
  localparam int CMP_W = 13;

  // Input tdata layout, lowest bit first
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_COL_LSB   = IN_IDX_LSB + IDX_W;
  localparam int IN_ROW_LSB   = IN_COL_LSB + COL_W;
  localparam int IN_RED_LSB   = IN_ROW_LSB + ROW_W;
  localparam int IN_GREEN_LSB = IN_RED_LSB + COLOR_W;
  localparam int IN_BLUE_LSB  = IN_GREEN_LSB + COLOR_W;
  localparam int IN_TDATA_W   = 56;

  // Output tdata layout, lowest bit first
  localparam int OUT_ADDR_LSB = 0;
  localparam int OUT_RGB_LSB  = ADDR_W;
  localparam int OUT_TDATA_W  = 48;

  // Configuration reset values
  localparam logic [SCR_W-1:0]    SCREEN_WIDTH_RST  = 12'd480;
  localparam logic [SCR_W-1:0]    SCREEN_HEIGHT_RST = 12'd320;
  localparam logic [SCR_W-1:0]    PAN_RST           = 12'd0;
  localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST   = 16'd960;
  localparam logic [SCALE_W-1:0]  SCALE_RST         = 16'd256;
  localparam logic [SCR_W-1:0]    MARGIN_RST        = 12'd0;

  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_PIXEL   = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_PAN_X         = 3'd2,
    REG_PAN_Y         = 3'd3,
    REG_LINE_STRIDE   = 3'd4,
    REG_SCALE_Q8      = 3'd5,
    REG_MARGIN_X      = 3'd6,
    REG_MARGIN_Y      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // Palette write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] index;
    rgb_t             rgb;
  } pal_wr_t;

  // Pack to red 5, green 6, blue 5
  function automatic logic [RGB565_W-1:0] pack565(rgb_t c);
    return {c.red[7:3], c.green[7:2], c.blue[7:3]};
  endfunction

endpackage

// ===== hdl/prspw_palette.sv =====
// Palette memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module prspw_palette #(
  parameter int PALETTE_SIZE = 256
) (
  input  logic                        clk,
  input  prspw_pkg::pal_wr_t          wr,
  input  logic                        rd_en,
  input  logic [prspw_pkg::IDX_W-1:0] rd_index,
  output prspw_pkg::rgb_t             rd_data
);

  localparam int AW = $clog2(PALETTE_SIZE);

  prspw_pkg::rgb_t mem [PALETTE_SIZE];
  prspw_pkg::rgb_t rd_data_r;

  // Store palette entries
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.index[AW-1:0]] <= wr.rgb;
    end
  end

  // Read when the first pipeline stage loads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_index[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/palette_rotate_scale_pixel_writer.sv =====
// Throughput: one item per cycle unless out_tready stalls the result channel; six
// register stages (input capture and palette read, scale multiply, margin add and
// bounds check, pan add, stride multiply, address sum), each with its own valid bit,
// so bubbles close up under stall.
// Reset clears all stage valid bits and loads the register defaults; the
// palette is not cleared and must be loaded before pixels use it.
`timescale 1ns / 1ps

module palette_rotate_scale_pixel_writer #(
  parameter int SRC_WIDTH       = 320,
  parameter int SRC_HEIGHT      = 200,
  parameter int BYTES_PER_PIXEL = 2,
  parameter int PALETTE_SIZE    = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // color_index[7:0], src_col[16:8], src_row[24:17], red_in[32:25],
  // green_in[40:33], blue_in[48:41], zero fill[55:49]
  input  logic [prspw_pkg::IN_TDATA_W-1:0]  in_tdata,
  // cmd[0]
  input  logic [0:0]                        in_tuser,
  // Result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // byte_address[29:0], pixel_rgb565[45:30], zero fill[47:46]
  output logic [prspw_pkg::OUT_TDATA_W-1:0] out_tdata,
  // write_valid[0]
  output logic [0:0]                        out_tuser,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [prspw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prspw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int FLIP_W = $clog2(SRC_WIDTH);
  localparam int BPP_W  = $clog2(BYTES_PER_PIXEL + 1);
  localparam int PX_W   = prspw_pkg::ROW_W + prspw_pkg::SCALE_W;
  localparam int PY_W   = FLIP_W + prspw_pkg::SCALE_W;
  localparam int FX_W   = PX_W - prspw_pkg::FRAC_W + 1;
  localparam int FY_W   = PY_W - prspw_pkg::FRAC_W + 1;
  localparam int SX_W   = FX_W + 1;
  localparam int SY_W   = FY_W + 1;
  localparam int AX_W   = SX_W + BPP_W;
  localparam int AY_W   = SY_W + prspw_pkg::STRIDE_W;
  localparam int CMP_W  = prspw_pkg::CMP_W;
  localparam int ADDR_W = prspw_pkg::ADDR_W;
  localparam int RGB_W  = prspw_pkg::RGB565_W;
  localparam int SCR_W  = prspw_pkg::SCR_W;

  // Configuration registers
  logic [SCR_W-1:0]               screen_width_r, screen_height_r;
  logic [SCR_W-1:0]               pan_x_r, pan_y_r, margin_x_r, margin_y_r;
  logic [prspw_pkg::STRIDE_W-1:0] line_stride_r;
  logic [prspw_pkg::SCALE_W-1:0]  scale_q8_r;

  // Stage valid bits and load enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_tvalid_r;
  logic en1, en2, en3, en4, en5, en_out;
  logic in_acc;

  // Input field unpacking
  logic [prspw_pkg::IDX_W-1:0] in_idx;
  logic [prspw_pkg::COL_W-1:0] in_col;
  logic [prspw_pkg::ROW_W-1:0] in_row;
  prspw_pkg::rgb_t             in_rgb;
  logic                        in_is_pixel;
  logic                        in_pal;
  logic                        in_src_ok;
  logic [CMP_W-1:0]            in_flip;

  prspw_pkg::pal_wr_t pal_wr;
  prspw_pkg::rgb_t    pal_q;

  // Stage 1: captured coordinates
  logic                s1_pix_r, s1_pix_nxt;
  logic                s1_pal_r, s1_pal_nxt;
  logic [FLIP_W-1:0]   s1_flip_r, s1_flip_nxt;
  logic [prspw_pkg::ROW_W-1:0] s1_row_r, s1_row_nxt;

  // Stage 2: scaled products and packed color
  logic                s2_pix_r, s2_pix_nxt;
  logic [RGB_W-1:0]    s2_rgb_r, s2_rgb_nxt;
  logic [PX_W-1:0]     s2_px_r, s2_px_nxt;
  logic [PY_W-1:0]     s2_py_r, s2_py_nxt;

  // Stage 3: screen position and bounds check
  logic                s3_hit_r, s3_hit_nxt;
  logic [RGB_W-1:0]    s3_rgb_r;
  logic [FX_W-1:0]     s3_fx_r, s3_fx_nxt;
  logic [FY_W-1:0]     s3_fy_r, s3_fy_nxt;

  // Stage 4: panned position
  logic                s4_hit_r;
  logic [RGB_W-1:0]    s4_rgb_r;
  logic [SX_W-1:0]     s4_sx_r, s4_sx_nxt;
  logic [SY_W-1:0]     s4_sy_r, s4_sy_nxt;

  // Stage 5: byte offsets
  logic                s5_hit_r;
  logic [RGB_W-1:0]    s5_rgb_r;
  logic [AX_W-1:0]     s5_ax_r, s5_ax_nxt;
  logic [ADDR_W-1:0]   s5_ay_r, s5_ay_nxt;
  logic [AY_W-1:0]     ay_full;

  // Output register
  logic                out_hit_r;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [RGB_W-1:0]    out_rgb_r, out_rgb_nxt;

  // Stage enables: a stage loads when empty or when its successor loads
  assign en_out    = !out_tvalid_r || out_tready;
  assign en5       = !v5_r || en_out;
  assign en4       = !v4_r || en5;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign in_acc    = in_tvalid && en1;
  assign cfg_ready = 1'b1;

  // Unpack input fields
  assign in_idx = in_tdata[prspw_pkg::IN_IDX_LSB +: prspw_pkg::IDX_W];
  assign in_col = in_tdata[prspw_pkg::IN_COL_LSB +: prspw_pkg::COL_W];
  assign in_row = in_tdata[prspw_pkg::IN_ROW_LSB +: prspw_pkg::ROW_W];
  assign in_rgb = '{red:   in_tdata[prspw_pkg::IN_RED_LSB   +: prspw_pkg::COLOR_W],
                    green: in_tdata[prspw_pkg::IN_GREEN_LSB +: prspw_pkg::COLOR_W],
                    blue:  in_tdata[prspw_pkg::IN_BLUE_LSB  +: prspw_pkg::COLOR_W]};
  assign in_is_pixel = (prspw_pkg::cmd_t'(in_tuser[0]) == prspw_pkg::CMD_PIXEL);
  assign in_pal      = ({1'b0, in_idx} < (prspw_pkg::IDX_W + 1)'(PALETTE_SIZE));
  assign in_src_ok   = (CMP_W'(in_col) < CMP_W'(SRC_WIDTH)) &&
                       (CMP_W'(in_row) < CMP_W'(SRC_HEIGHT));
  assign in_flip     = CMP_W'(SRC_WIDTH - 1) - CMP_W'(in_col);

  // Palette write on an accepted palette transaction inside the palette
  assign pal_wr = '{en:    in_acc && !in_is_pixel && in_pal,
                    index: in_idx,
                    rgb:   in_rgb};

  prspw_palette #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_palette (
    .clk      (clk),
    .wr       (pal_wr),
    .rd_en    (en1),
    .rd_index (in_idx),
    .rd_data  (pal_q)
  );

  // Next values for every stage
  always_comb begin
    s1_pix_nxt  = in_is_pixel && in_src_ok;
    s1_pal_nxt  = in_pal;
    s1_flip_nxt = in_flip[FLIP_W-1:0];
    s1_row_nxt  = in_row;

    s2_pix_nxt = s1_pix_r;
    s2_rgb_nxt = s1_pal_r ? prspw_pkg::pack565(pal_q) : '0;
    s2_px_nxt  = PX_W'(s1_row_r) * PX_W'(scale_q8_r);
    s2_py_nxt  = PY_W'(s1_flip_r) * PY_W'(scale_q8_r);

    s3_fx_nxt  = FX_W'(s2_px_r[PX_W-1:prspw_pkg::FRAC_W]) + FX_W'(margin_x_r);
    s3_fy_nxt  = FY_W'(s2_py_r[PY_W-1:prspw_pkg::FRAC_W]) + FY_W'(margin_y_r);
    s3_hit_nxt = s2_pix_r && (s3_fx_nxt < FX_W'(screen_width_r)) &&
                 (s3_fy_nxt < FY_W'(screen_height_r));

    s4_sx_nxt = SX_W'(s3_fx_r) + SX_W'(pan_x_r);
    s4_sy_nxt = SY_W'(s3_fy_r) + SY_W'(pan_y_r);

    s5_ax_nxt = AX_W'(s4_sx_r) * AX_W'(BYTES_PER_PIXEL);
    ay_full   = AY_W'(s4_sy_r) * AY_W'(line_stride_r);
    s5_ay_nxt = ay_full[ADDR_W-1:0];

    out_addr_nxt = s5_hit_r ? (ADDR_W'(s5_ax_r) + s5_ay_r) : '0;
    out_rgb_nxt  = s5_hit_r ? s5_rgb_r : '0;
  end

  // Hold valid bits and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r            <= 1'b0;
      v2_r            <= 1'b0;
      v3_r            <= 1'b0;
      v4_r            <= 1'b0;
      v5_r            <= 1'b0;
      out_tvalid_r    <= 1'b0;
      screen_width_r  <= prspw_pkg::SCREEN_WIDTH_RST;
      screen_height_r <= prspw_pkg::SCREEN_HEIGHT_RST;
      pan_x_r         <= prspw_pkg::PAN_RST;
      pan_y_r         <= prspw_pkg::PAN_RST;
      line_stride_r   <= prspw_pkg::LINE_STRIDE_RST;
      scale_q8_r      <= prspw_pkg::SCALE_RST;
      margin_x_r      <= prspw_pkg::MARGIN_RST;
      margin_y_r      <= prspw_pkg::MARGIN_RST;
    end else begin
      if (en1)    v1_r         <= in_tvalid;
      if (en2)    v2_r         <= v1_r;
      if (en3)    v3_r         <= v2_r;
      if (en4)    v4_r         <= v3_r;
      if (en5)    v5_r         <= v4_r;
      if (en_out) out_tvalid_r <= v5_r;
      if (cfg_valid) begin
        unique case (prspw_pkg::cfg_reg_t'(cfg_index))
          prspw_pkg::REG_SCREEN_WIDTH:  screen_width_r  <= cfg_data[SCR_W-1:0];
          prspw_pkg::REG_SCREEN_HEIGHT: screen_height_r <= cfg_data[SCR_W-1:0];
          prspw_pkg::REG_PAN_X:         pan_x_r         <= cfg_data[SCR_W-1:0];
          prspw_pkg::REG_PAN_Y:         pan_y_r         <= cfg_data[SCR_W-1:0];
          prspw_pkg::REG_LINE_STRIDE:   line_stride_r   <= cfg_data;
          prspw_pkg::REG_SCALE_Q8:      scale_q8_r      <= cfg_data;
          prspw_pkg::REG_MARGIN_X:      margin_x_r      <= cfg_data[SCR_W-1:0];
          prspw_pkg::REG_MARGIN_Y:      margin_y_r      <= cfg_data[SCR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Advance payload stages
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_pix_r  <= s1_pix_nxt;
      s1_pal_r  <= s1_pal_nxt;
      s1_flip_r <= s1_flip_nxt;
      s1_row_r  <= s1_row_nxt;
    end
    if (en2) begin
      s2_pix_r <= s2_pix_nxt;
      s2_rgb_r <= s2_rgb_nxt;
      s2_px_r  <= s2_px_nxt;
      s2_py_r  <= s2_py_nxt;
    end
    if (en3) begin
      s3_hit_r <= s3_hit_nxt;
      s3_rgb_r <= s2_rgb_r;
      s3_fx_r  <= s3_fx_nxt;
      s3_fy_r  <= s3_fy_nxt;
    end
    if (en4) begin
      s4_hit_r <= s3_hit_r;
      s4_rgb_r <= s3_rgb_r;
      s4_sx_r  <= s4_sx_nxt;
      s4_sy_r  <= s4_sy_nxt;
    end
    if (en5) begin
      s5_hit_r <= s4_hit_r;
      s5_rgb_r <= s4_rgb_r;
      s5_ax_r  <= s5_ax_nxt;
      s5_ay_r  <= s5_ay_nxt;
    end
    if (en_out) begin
      out_hit_r  <= s5_hit_r;
      out_addr_r <= out_addr_nxt;
      out_rgb_r  <= out_rgb_nxt;
    end
  end

  // Drive the result channel
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {{(prspw_pkg::OUT_TDATA_W - ADDR_W - RGB_W){1'b0}},
                       out_rgb_r, out_addr_r};

`ifndef SYNTH
  // A result that is not written carries all-zero data
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("off-screen or palette result with nonzero data");

  // A held middle stage keeps its transaction
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !en3) |=> v3_r)
    else $error("stage 3 transaction dropped while stalled");

  // A full pipeline with a stalled output takes no input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && v5_r && out_tvalid_r && !out_tready)
      |-> !in_tready)
    else $error("input accepted while pipeline full and stalled");

  // Palette writes come only from accepted palette transactions
  a_pal_write: assert property (@(posedge clk) disable iff (!rst_n)
    pal_wr.en |-> (in_tvalid && in_tready &&
                   (prspw_pkg::cmd_t'(in_tuser[0]) == prspw_pkg::CMD_PALETTE)))
    else $error("palette written outside a palette transaction");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the palette rotate/scale pixel writer: directed and random traffic.
`timescale 1ns / 1ps

module tb;
  import prspw_pkg::*;

  localparam int SRC_W       = 320;
  localparam int SRC_H       = 200;
  localparam int BPP         = 2;
  localparam int PAL_N       = 256;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASE_ITEMS = 140;

  typedef enum int {
    IDLE_NONE,
    IDLE_TX,
    IDLE_RX,
    IDLE_BOTH
  } idle_mode_t;

  // One input transaction, unpacked into its fields
  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] idx;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    rgb_t             rgb;
  } pixel_item_t;

  // One frame store write as the block should report it
  typedef struct packed {
    logic                wr_valid;
    logic [ADDR_W-1:0]   addr;
    logic [RGB565_W-1:0] rgb565;
  } frame_write_t;

  typedef struct packed {
    logic [SCR_W-1:0]    width;
    logic [SCR_W-1:0]    height;
    logic [SCR_W-1:0]    pan_x;
    logic [SCR_W-1:0]    pan_y;
    logic [STRIDE_W-1:0] stride;
    logic [SCALE_W-1:0]  scale;
    logic [SCR_W-1:0]    margin_x;
    logic [SCR_W-1:0]    margin_y;
  } screen_cfg_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [0:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // Predictor state: palette shadow and live register values
  frame_write_t expected_writes[$];
  rgb_t         palette_copy[PAL_N];
  bit           pal_loaded[PAL_N];
  screen_cfg_t  live_cfg = {SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, PAN_RST, PAN_RST,
                            LINE_STRIDE_RST, SCALE_RST, MARGIN_RST, MARGIN_RST};

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_req  = 0;
  int rx_hold_left = 0;
  int quiet_cycles = 0;
  int n_fail       = 0;

  palette_rotate_scale_pixel_writer #(
    .SRC_WIDTH      (SRC_W),
    .SRC_HEIGHT     (SRC_H),
    .BYTES_PER_PIXEL(BPP),
    .PALETTE_SIZE   (PAL_N)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Update the palette shadow, or compute where a pixel lands and its color
  function automatic frame_write_t predict_frame_write(input pixel_item_t it);
    frame_write_t r;
    logic [63:0]  fb_x;
    logic [63:0]  fb_y;
    logic [63:0]  addr;
    rgb_t         c;
    r = '0;
    if (it.cmd == CMD_PALETTE) begin
      if (int'(it.idx) < PAL_N) begin
        palette_copy[it.idx] = it.rgb;
        pal_loaded[it.idx]   = 1'b1;
      end
      return r;
    end
    if (64'(it.col) >= 64'(SRC_W) || 64'(it.row) >= 64'(SRC_H))
      return r;
    // rotate by 90 degrees: source rows run along x, reversed columns along y
    fb_x = ((64'(it.row) * 64'(live_cfg.scale)) >> FRAC_W) + 64'(live_cfg.margin_x);
    fb_y = (((64'(SRC_W) - 64'd1 - 64'(it.col)) * 64'(live_cfg.scale)) >> FRAC_W)
           + 64'(live_cfg.margin_y);
    if (fb_x >= 64'(live_cfg.width) || fb_y >= 64'(live_cfg.height))
      return r;
    addr = (fb_x + 64'(live_cfg.pan_x)) * 64'(BPP)
           + (fb_y + 64'(live_cfg.pan_y)) * 64'(live_cfg.stride);
    c = (int'(it.idx) < PAL_N) ? palette_copy[it.idx] : rgb_t'(0);
    r.wr_valid = 1'b1;
    r.addr     = addr[ADDR_W-1:0];
    r.rgb565   = {c.red[7:3], c.green[7:2], c.blue[7:3]};
    return r;
  endfunction

  function automatic pixel_item_t pal_item(input int idx, input int red, input int green,
                                           input int blue);
    pixel_item_t it;
    it           = '0;
    it.cmd       = CMD_PALETTE;
    it.idx       = IDX_W'(idx);
    it.rgb.red   = COLOR_W'(red);
    it.rgb.green = COLOR_W'(green);
    it.rgb.blue  = COLOR_W'(blue);
    return it;
  endfunction

  function automatic pixel_item_t pix_item(input int idx, input int col, input int row);
    pixel_item_t it;
    it     = '0;
    it.cmd = CMD_PIXEL;
    it.idx = IDX_W'(idx);
    it.col = COL_W'(col);
    it.row = ROW_W'(row);
    return it;
  endfunction

  // Mostly in-range pixels, a share of palette writes, some off-source coordinates
  function automatic pixel_item_t random_item();
    pixel_item_t it;
    it.cmd = ($urandom_range(99) < 20) ? CMD_PALETTE : CMD_PIXEL;
    it.idx = IDX_W'($urandom_range(255));
    if ($urandom_range(9) == 0) begin
      it.col = COL_W'($urandom_range(511));
      it.row = ROW_W'($urandom_range(255));
    end else begin
      it.col = COL_W'($urandom_range(SRC_W - 1));
      it.row = ROW_W'($urandom_range(SRC_H - 1));
    end
    it.rgb = rgb_t'($urandom_range(24'hFFFFFF));
    // never read a palette entry that was not loaded yet
    if (it.cmd == CMD_PIXEL && !pal_loaded[it.idx])
      it.cmd = CMD_PALETTE;
    return it;
  endfunction

  function automatic screen_cfg_t make_cfg(input int w, input int h, input int px, input int py,
                                           input int stride, input int scale, input int mx,
                                           input int my);
    screen_cfg_t s;
    s.width    = SCR_W'(w);
    s.height   = SCR_W'(h);
    s.pan_x    = SCR_W'(px);
    s.pan_y    = SCR_W'(py);
    s.stride   = STRIDE_W'(stride);
    s.scale    = SCALE_W'(scale);
    s.margin_x = SCR_W'(mx);
    s.margin_y = SCR_W'(my);
    return s;
  endfunction

  // Size the screen around the scaled image so both sides of the bounds get hit
  function automatic screen_cfg_t random_cfg();
    int fit_w;
    int fit_h;
    int scale;
    int mx;
    int my;
    scale = $urandom_range(600, 16);
    mx    = $urandom_range(200);
    my    = $urandom_range(200);
    fit_w = ((SRC_H * scale) >> FRAC_W) + mx;
    fit_h = ((SRC_W * scale) >> FRAC_W) + my;
    return make_cfg($urandom_range(fit_w + 40, fit_w / 2 + 1),
                    $urandom_range(fit_h + 40, fit_h / 2 + 1),
                    $urandom_range(4095), $urandom_range(4095), $urandom_range(65535),
                    scale, mx, my);
  endfunction

  task automatic set_idle(input idle_mode_t m);
    tx_idle_pct  = (m == IDLE_TX) ? 74 : (m == IDLE_BOTH) ? 15 : 0;
    rx_stall_pct = (m == IDLE_RX) ? 74 : (m == IDLE_BOTH) ? 15 : 0;
  endtask

  // Offer one item after a random gap; valid stays high for a following item
  task automatic send_item(input pixel_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {7'd0, it.rgb.blue, it.rgb.green, it.rgb.red, it.row, it.col, it.idx};
    do @(posedge clk); while (!in_tready);
    expected_writes.push_back(predict_frame_write(it));
  endtask

  // Hold the sender until every expected result has arrived
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SCREEN_WIDTH:  live_cfg.width    = val[SCR_W-1:0];
      REG_SCREEN_HEIGHT: live_cfg.height   = val[SCR_W-1:0];
      REG_PAN_X:         live_cfg.pan_x    = val[SCR_W-1:0];
      REG_PAN_Y:         live_cfg.pan_y    = val[SCR_W-1:0];
      REG_LINE_STRIDE:   live_cfg.stride   = val[STRIDE_W-1:0];
      REG_SCALE_Q8:      live_cfg.scale    = val[SCALE_W-1:0];
      REG_MARGIN_X:      live_cfg.margin_x = val[SCR_W-1:0];
      REG_MARGIN_Y:      live_cfg.margin_y = val[SCR_W-1:0];
      default: ;
    endcase
  endtask

  // Write every register; call only while the block is idle
  task automatic load_config(input screen_cfg_t s);
    write_reg(REG_SCREEN_WIDTH,  CFG_DATA_W'(s.width));
    write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(s.height));
    write_reg(REG_PAN_X,         CFG_DATA_W'(s.pan_x));
    write_reg(REG_PAN_Y,         CFG_DATA_W'(s.pan_y));
    write_reg(REG_LINE_STRIDE,   s.stride);
    write_reg(REG_SCALE_Q8,      s.scale);
    write_reg(REG_MARGIN_X,      CFG_DATA_W'(s.margin_x));
    write_reg(REG_MARGIN_Y,      CFG_DATA_W'(s.margin_y));
    cfg_valid <= 1'b0;
  endtask

  // Corners of the source, off-source coordinates, palette overwrite, extreme settings
  task automatic test_directed();
    set_idle(IDLE_NONE);
    send_item(pal_item(8'h00, 8'h00, 8'h00, 8'h00));
    send_item(pal_item(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(pal_item(8'hA5, 8'h87, 8'h43, 8'hF1));
    send_item(pix_item(8'hFF, 0, 0));
    send_item(pix_item(8'h00, SRC_W - 1, SRC_H - 1));
    send_item(pix_item(8'hA5, 160, 100));
    send_item(pix_item(8'hA5, SRC_W, 0));
    send_item(pix_item(8'hFF, 511, 255));
    send_item(pix_item(8'hFF, 0, SRC_H));
    send_item(pal_item(8'hFF, 8'h12, 8'h34, 8'h56));
    send_item(pix_item(8'hFF, 5, 7));
    // one-pixel screen: only the far source columns land on it
    drain_results();
    load_config(make_cfg(1, 1, 0, 0, 0, 1, 0, 0));
    send_item(pix_item(8'hA5, SRC_W - 1, SRC_H - 1));
    send_item(pix_item(8'hA5, 0, 0));
    // largest screen, pans, stride and scale
    drain_results();
    load_config(make_cfg(4095, 4095, 4095, 4095, 65535, 65535, 0, 0));
    send_item(pix_item(8'h00, SRC_W - 1, 0));
    send_item(pix_item(8'hFF, SRC_W - 1, 1));
    send_item(pix_item(8'hA5, SRC_W - 2, 0));
    send_item(pix_item(8'hA5, 0, SRC_H - 1));
    // margins alone push everything off screen
    drain_results();
    load_config(make_cfg(4095, 4095, 0, 0, 960, 256, 4095, 4095));
    send_item(pix_item(8'hFF, SRC_W - 1, 0));
    send_item(pix_item(8'h00, 0, SRC_H - 1));
  endtask

  task automatic test_palette_fill();
    set_idle(IDLE_TX);
    for (int i = 0; i < PAL_N; i++)
      send_item(pal_item(i, $urandom_range(255), $urandom_range(255), $urandom_range(255)));
  endtask

  // One register setting per phase, idle modes rotating
  task automatic test_random_phases();
    screen_cfg_t s;
    for (int p = 0; p < 7; p++) begin
      drain_results();
      case (p)
        0: s = make_cfg(480, 320, 0, 0, 960, 256, 0, 0);
        1: s = make_cfg(4095, 4095, 4095, 4095, 65535, 65535, 0, 0);
        2: s = make_cfg(4095, 4095, $urandom_range(4095), $urandom_range(4095),
                        $urandom_range(65535), 1, $urandom_range(4094), $urandom_range(4094));
        default: s = random_cfg();
      endcase
      load_config(s);
      set_idle(idle_mode_t'(p % 4));
      repeat (PHASE_ITEMS) send_item(random_item());
    end
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_output_backpressure();
    drain_results();
    set_idle(IDLE_NONE);
    rx_hold_req = 300;
    repeat (64) send_item(random_item());
  endtask

  task automatic test_drain_pause();
    set_idle(IDLE_BOTH);
    repeat (3) begin
      repeat (8) send_item(random_item());
      drain_results();
    end
  endtask

  // Receiver: long hold on request, otherwise random stalls
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    frame_write_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_writes.size() == 0) begin
        $error("result transaction with no expectation pending");
        n_fail++;
      end else begin
        want = expected_writes.pop_front();
        if (out_tuser[0] !== want.wr_valid) begin
          $error("write_valid: expected %0d, got %0d", want.wr_valid, out_tuser[0]);
          n_fail++;
        end
        if (out_tdata[OUT_ADDR_LSB +: ADDR_W] !== want.addr) begin
          $error("byte_address: expected 0x%08h, got 0x%08h", want.addr,
                 out_tdata[OUT_ADDR_LSB +: ADDR_W]);
          n_fail++;
        end
        if (out_tdata[OUT_RGB_LSB +: RGB565_W] !== want.rgb565) begin
          $error("pixel_rgb565: expected 0x%04h, got 0x%04h", want.rgb565,
                 out_tdata[OUT_RGB_LSB +: RGB565_W]);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_palette_fill();
    test_random_phases();
    test_output_backpressure();
    test_drain_pause();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_fail == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/prspw_pkg.sv
hdl/prspw_palette.sv
hdl/palette_rotate_scale_pixel_writer.sv
tb/tb.sv
